/* hw/rtl/bcc_pkg.sv */
`timescale 1ns / 1ps
// Package for the button click classifier: register map, reset values and
// default widths. Used by the interfaces, the top level and the checker.
package bcc_pkg;

    // Default width of the saturating tick timers.
    localparam int unsigned TimerBitsDefault = 16;

    // Widths fixed by the register map and the result fields.
    localparam int unsigned CfgTicksW = 16;
    localparam int unsigned ModeCntW  = 5;
    localparam int unsigned ModeW     = 4;
    localparam int unsigned EdgeCntW  = 2;

    // APB port: four 32-bit registers at byte addresses 4*i.
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned ApbAddrW = 4;
    localparam int unsigned RegIdxW  = 2;

    typedef enum logic [RegIdxW-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_WINDOW     = 2'd1,
        REG_LONG_PRESS = 2'd2,
        REG_MODE_COUNT = 2'd3
    } reg_idx_t;

    // Register reset values.
    localparam logic [CfgTicksW-1:0] DebounceReset  = 16'd50;
    localparam logic [CfgTicksW-1:0] WindowReset    = 16'd500;
    localparam logic [CfgTicksW-1:0] LongPressReset = 16'd1000;
    localparam logic [ModeCntW-1:0]  ModeCountReset = 5'd4;

    // Edge count at which the next accepted edge completes a double click.
    localparam logic [EdgeCntW-1:0] LastEdgeCount = 2'd3;

endpackage

/* hw/rtl/bcc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the button click classifier.
// Depends on bcc_pkg for the width of the mode field.
interface bcc_in_if;
    logic valid;
    logic ready;
    logic op;
    logic pressed;

    modport source (output valid, output op, output pressed, input ready);
    modport sink (input valid, input op, input pressed, output ready);
endinterface

interface bcc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       long_press;
    logic                       double_click;
    logic [bcc_pkg::ModeW-1:0]  mode;

    modport source (output valid, output long_press, output double_click, output mode,
                    input ready);
    modport sink (input valid, input long_press, input double_click, input mode,
                  output ready);
endinterface

/* hw/rtl/button_click_classifier.sv */
`timescale 1ns / 1ps
// Button click classifier: each accepted item has its result registered in the
// output register; one item per cycle sustained while the output is not stalled,
// since the state update is a single short pass of compares and adds per item.
// rst_n clears all classifier state (edge timer saturated, window timer zeroed,
// idle, deadline disarmed) and loads the register reset values; the result
// payload is not reset. Depends on bcc_pkg and the channel interfaces in bcc_if.sv.
module button_click_classifier #(
    parameter int unsigned TIMER_BITS = bcc_pkg::TimerBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [bcc_pkg::ApbDataW-1:0]  pwdata,
    output logic [bcc_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready,
    // Item channels
    bcc_in_if.sink                        in_ch,
    bcc_out_if.source                     out_ch
);

    // Common compare width for timers against the 16-bit registers, and the
    // sum width used when arming the long-press deadline.
    localparam int unsigned CmpW = (TIMER_BITS > bcc_pkg::CfgTicksW) ?
                                   TIMER_BITS : bcc_pkg::CfgTicksW;
    localparam int unsigned SumW = CmpW + 1;
    localparam int unsigned DeadW = TIMER_BITS + 1;

    localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};
    localparam logic [DeadW-1:0]      DeadOff  = {DeadW{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers. The APB port is always ready; a write lands
    // on the access cycle. Only the word index of the address is decoded.
    // ------------------------------------------------------------------
    logic [bcc_pkg::CfgTicksW-1:0] debounce_ticks_reg;
    logic [bcc_pkg::CfgTicksW-1:0] window_ticks_reg;
    logic [bcc_pkg::CfgTicksW-1:0] long_press_ticks_reg;
    logic [bcc_pkg::ModeCntW-1:0]  mode_count_reg;

    bcc_pkg::reg_idx_t reg_idx;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = bcc_pkg::reg_idx_t'(paddr[bcc_pkg::ApbAddrW-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= bcc_pkg::DebounceReset;
            window_ticks_reg     <= bcc_pkg::WindowReset;
            long_press_ticks_reg <= bcc_pkg::LongPressReset;
            mode_count_reg       <= bcc_pkg::ModeCountReset;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                bcc_pkg::REG_DEBOUNCE:
                    debounce_ticks_reg <= pwdata[bcc_pkg::CfgTicksW-1:0];
                bcc_pkg::REG_WINDOW:
                    window_ticks_reg <= pwdata[bcc_pkg::CfgTicksW-1:0];
                bcc_pkg::REG_LONG_PRESS:
                    long_press_ticks_reg <= pwdata[bcc_pkg::CfgTicksW-1:0];
                bcc_pkg::REG_MODE_COUNT:
                    mode_count_reg <= pwdata[bcc_pkg::ModeCntW-1:0];
                default:
                    mode_count_reg <= mode_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bcc_pkg::REG_DEBOUNCE:
                prdata = bcc_pkg::ApbDataW'(debounce_ticks_reg);
            bcc_pkg::REG_WINDOW:
                prdata = bcc_pkg::ApbDataW'(window_ticks_reg);
            bcc_pkg::REG_LONG_PRESS:
                prdata = bcc_pkg::ApbDataW'(long_press_ticks_reg);
            bcc_pkg::REG_MODE_COUNT:
                prdata = bcc_pkg::ApbDataW'(mode_count_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Classifier state. Every accepted item updates the state in one pass
    // and writes its result into the output register, so the next item can
    // follow in the very next cycle when the output register drains.
    // ------------------------------------------------------------------
    logic [TIMER_BITS-1:0]        since_edge_reg,    since_edge_next;
    logic [TIMER_BITS-1:0]        window_time_reg,   window_time_next;
    logic [DeadW-1:0]             long_deadline_reg, long_deadline_next;
    logic                         idle_reg,          idle_next;
    logic [bcc_pkg::EdgeCntW-1:0] edge_count_reg,    edge_count_next;
    logic                         held_long_reg,     held_long_next;
    logic [bcc_pkg::ModeW-1:0]    mode_index_reg,    mode_index_next;
    logic                         pulse;

    // Output register
    logic                         out_valid_reg;
    logic                         long_press_reg;
    logic                         double_click_reg;
    logic [bcc_pkg::ModeW-1:0]    mode_reg;

    logic                         in_fire;
    logic [TIMER_BITS-1:0]        window_inc;
    logic [TIMER_BITS-1:0]        arm_base;
    logic [SumW-1:0]              arm_sum;
    logic [DeadW-1:0]             arm_deadline;
    logic [bcc_pkg::ModeCntW-1:0] mode_step;
    logic                         edge_taken;

    // The item is taken whenever the output register is empty or drains now.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign window_inc = window_time_reg + 1'b1;

    // A press from idle restarts the window, so the deadline is armed from
    // zero; inside the window it is armed from the running window timer.
    assign arm_base     = idle_reg ? '0 : window_time_reg;
    assign arm_sum      = SumW'(arm_base) + SumW'(long_press_ticks_reg);
    assign arm_deadline = (arm_sum > SumW'(TimerMax)) ? DeadOff : DeadW'(arm_sum);

    // Mode steps and wraps at mode_count; the step is formed one bit wider so
    // that a step to sixteen is compared with mode_count before truncation.
    assign mode_step = bcc_pkg::ModeCntW'(mode_index_reg) + 1'b1;

    // Edges within the debounce time are dropped unless the block is idle.
    assign edge_taken = idle_reg ||
                        !(CmpW'(since_edge_reg) < CmpW'(debounce_ticks_reg));

    always_comb
    begin
        since_edge_next    = since_edge_reg;
        window_time_next   = window_time_reg;
        long_deadline_next = long_deadline_reg;
        idle_next          = idle_reg;
        edge_count_next    = edge_count_reg;
        held_long_next     = held_long_reg;
        mode_index_next    = mode_index_reg;
        pulse              = 1'b0;

        if (!in_ch.op)
        begin
            // Tick: saturating timers. The window end and the long-press
            // check only fire on a tick that really advanced the window timer.
            if (since_edge_reg != TimerMax)
            begin
                since_edge_next = since_edge_reg + 1'b1;
            end
            if (window_time_reg != TimerMax)
            begin
                window_time_next = window_inc;
                if (CmpW'(window_inc) == CmpW'(window_ticks_reg))
                begin
                    idle_next = 1'b1;
                end
                if (long_deadline_reg != DeadOff &&
                    DeadW'(window_inc) == long_deadline_reg)
                begin
                    if (in_ch.pressed)
                    begin
                        held_long_next = 1'b1;
                    end
                    long_deadline_next = DeadOff;
                end
            end
        end
        else if (edge_taken)
        begin
            since_edge_next = '0;
            held_long_next  = 1'b0;
            if (idle_reg)
            begin
                if (in_ch.pressed)
                begin
                    idle_next          = 1'b0;
                    edge_count_next    = 2'd1;
                    window_time_next   = '0;
                    long_deadline_next = arm_deadline;
                end
                else
                begin
                    edge_count_next = '0;
                end
            end
            else
            begin
                if (in_ch.pressed)
                begin
                    long_deadline_next = arm_deadline;
                end
                if (edge_count_reg == bcc_pkg::LastEdgeCount)
                begin
                    // The edge taken at LastEdgeCount within the window completes a double click.
                    edge_count_next = '0;
                    pulse           = 1'b1;
                    idle_next       = 1'b1;
                    if (mode_step >= mode_count_reg)
                    begin
                        mode_index_next = '0;
                    end
                    else
                    begin
                        mode_index_next = mode_step[bcc_pkg::ModeW-1:0];
                    end
                end
                else
                begin
                    edge_count_next = edge_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_edge_reg    <= TimerMax;
            window_time_reg   <= '0;
            long_deadline_reg <= DeadOff;
            idle_reg          <= 1'b1;
            edge_count_reg    <= '0;
            held_long_reg     <= 1'b0;
            mode_index_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                since_edge_reg    <= since_edge_next;
                window_time_reg   <= window_time_next;
                long_deadline_reg <= long_deadline_next;
                idle_reg          <= idle_next;
                edge_count_reg    <= edge_count_next;
                held_long_reg     <= held_long_next;
                mode_index_reg    <= mode_index_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded with the updated state of each accepted item.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            long_press_reg   <= held_long_next;
            double_click_reg <= pulse;
            mode_reg         <= mode_index_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.long_press   = long_press_reg;
    assign out_ch.double_click = double_click_reg;
    assign out_ch.mode         = mode_reg;

endmodule

/* hw/rtl/bcc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the button click classifier, bound to the top level.
// Depends on bcc_pkg for the mode width.
module bcc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       long_press,
    input logic                       double_click,
    input logic [bcc_pkg::ModeW-1:0]  mode
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(long_press) &&
        $stable(double_click) && $stable(mode))
        else $error("result changed while stalled");

    // An empty output register never holds back the input.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // Every accepted item shows a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // A double click comes from an accepted edge, which clears long_press.
    a_click_not_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && double_click |-> !long_press)
        else $error("double click reported with long press");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .long_press   (out_ch.long_press),
    .double_click (out_ch.double_click),
    .mode         (out_ch.mode)
);
